// ----- rtl/clx_pkg.sv -----
// Shared types and opcode constants for the load/xor instruction executor.
package clx_pkg;

    localparam logic [7:0] OP_LD_BC_U16 = 8'h01;
    localparam logic [7:0] OP_LD_DE_U16 = 8'h11;
    localparam logic [7:0] OP_LD_HL_U16 = 8'h21;
    localparam logic [7:0] OP_LD_SP_U16 = 8'h31;
    localparam logic [7:0] OP_LD_HLD_A  = 8'h32;
    localparam logic [7:0] OP_XOR_B     = 8'hA8;
    localparam logic [7:0] OP_XOR_C     = 8'hA9;
    localparam logic [7:0] OP_XOR_D     = 8'hAA;
    localparam logic [7:0] OP_XOR_E     = 8'hAB;
    localparam logic [7:0] OP_XOR_H     = 8'hAC;
    localparam logic [7:0] OP_XOR_L     = 8'hAD;
    localparam logic [7:0] OP_XOR_A     = 8'hAF;

    // XOR source select, low three opcode bits
    localparam logic [2:0] SRC_B = 3'd0;
    localparam logic [2:0] SRC_C = 3'd1;
    localparam logic [2:0] SRC_D = 3'd2;
    localparam logic [2:0] SRC_E = 3'd3;
    localparam logic [2:0] SRC_H = 3'd4;
    localparam logic [2:0] SRC_L = 3'd5;

    localparam logic [15:0] PC_STEP_U16 = 16'd2;
    localparam logic [7:0]  FLAG_Z      = 8'h80;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] operand_low;
        logic [7:0] operand_high;
    } clx_in_t;

    typedef struct packed {
        logic        illegal;
        logic        mem_write_enable;
        logic [15:0] mem_write_address;
        logic [7:0]  mem_write_data;
        logic [7:0]  reg_a;
        logic [7:0]  reg_flags;
        logic [15:0] reg_bc;
        logic [15:0] reg_de;
        logic [15:0] reg_hl;
        logic [15:0] reg_sp;
        logic [15:0] reg_pc;
    } clx_out_t;

endpackage

// ----- rtl/clx_exec.sv -----
// Register file and combinational instruction decode/execute.
module clx_exec (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  clx_pkg::clx_in_t  item,
    output clx_pkg::clx_out_t result
);

    logic [7:0]  a_reg,  a_next;
    logic [7:0]  f_reg,  f_next;
    logic [15:0] bc_reg, bc_next;
    logic [15:0] de_reg, de_next;
    logic [15:0] hl_reg, hl_next;
    logic [15:0] sp_reg, sp_next;
    logic [15:0] pc_reg, pc_next;

    logic [15:0] imm;
    logic [7:0]  xor_src;
    logic [7:0]  xor_val;
    logic        bad;
    logic        we;

    assign imm = {item.operand_high, item.operand_low};

    always_comb begin
        case (item.opcode[2:0])
            clx_pkg::SRC_B: xor_src = bc_reg[15:8];
            clx_pkg::SRC_C: xor_src = bc_reg[7:0];
            clx_pkg::SRC_D: xor_src = de_reg[15:8];
            clx_pkg::SRC_E: xor_src = de_reg[7:0];
            clx_pkg::SRC_H: xor_src = hl_reg[15:8];
            clx_pkg::SRC_L: xor_src = hl_reg[7:0];
            default:        xor_src = a_reg;
        endcase
    end

    assign xor_val = a_reg ^ xor_src;

    always_comb begin
        a_next  = a_reg;
        f_next  = f_reg;
        bc_next = bc_reg;
        de_next = de_reg;
        hl_next = hl_reg;
        sp_next = sp_reg;
        pc_next = pc_reg;
        bad     = 1'b0;
        we      = 1'b0;
        unique case (item.opcode) inside
            clx_pkg::OP_LD_BC_U16: begin
                bc_next = imm;
                pc_next = pc_reg + clx_pkg::PC_STEP_U16;
            end
            clx_pkg::OP_LD_DE_U16: begin
                de_next = imm;
                pc_next = pc_reg + clx_pkg::PC_STEP_U16;
            end
            clx_pkg::OP_LD_HL_U16: begin
                hl_next = imm;
                pc_next = pc_reg + clx_pkg::PC_STEP_U16;
            end
            clx_pkg::OP_LD_SP_U16: begin
                sp_next = imm;
                pc_next = pc_reg + clx_pkg::PC_STEP_U16;
            end
            clx_pkg::OP_LD_HLD_A: begin
                we      = 1'b1;
                hl_next = hl_reg - 16'd1;
            end
            clx_pkg::OP_XOR_B, clx_pkg::OP_XOR_C, clx_pkg::OP_XOR_D,
            clx_pkg::OP_XOR_E, clx_pkg::OP_XOR_H, clx_pkg::OP_XOR_L,
            clx_pkg::OP_XOR_A: begin
                a_next = xor_val;
                f_next = (xor_val == 8'd0) ? clx_pkg::FLAG_Z : 8'd0;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg  <= '0;
            f_reg  <= '0;
            bc_reg <= '0;
            de_reg <= '0;
            hl_reg <= '0;
            sp_reg <= '0;
            pc_reg <= '0;
        end else if (fire) begin
            a_reg  <= a_next;
            f_reg  <= f_next;
            bc_reg <= bc_next;
            de_reg <= de_next;
            hl_reg <= hl_next;
            sp_reg <= sp_next;
            pc_reg <= pc_next;
        end
    end

    // Write fields are zero unless this transaction stores A
    always_comb begin
        result.illegal           = bad;
        result.mem_write_enable  = we;
        result.mem_write_address = we ? hl_reg : 16'd0;
        result.mem_write_data    = we ? a_reg : 8'd0;
        result.reg_a             = a_next;
        result.reg_flags         = f_next;
        result.reg_bc            = bc_next;
        result.reg_de            = de_next;
        result.reg_hl            = hl_next;
        result.reg_sp            = sp_next;
        result.reg_pc            = pc_next;
    end

endmodule

// ----- rtl/cpu_load_xor_execute_top.sv -----
// Top level: input register, executor and result register.
//
// Input channel s_valid/s_ready/s_data carries one fetched opcode and the
// two operand bytes read at PC and PC+1. Result channel m_valid/m_ready/
// m_data reports the illegal flag, any memory write (A stored at HL) and
// every register after the instruction.
// A transaction accepted into the input register is executed from there
// and its result is captured in the result register and shown from then on.
// Throughput: one transaction per cycle while the result register is free or
// being taken; the register file updates in the same cycle an item moves into
// the result register, so each instruction sees the state left by the previous one.
// Reset (aresetn low, synchronous) clears the register file to zero and drops
// both valid flags.
// While m_ready is low the result holds; one more item waits in the input
// register, after which s_ready drops until the result is taken.
module cpu_load_xor_execute_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  clx_pkg::clx_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output clx_pkg::clx_out_t  m_data
);

    logic              in_valid_reg;
    clx_pkg::clx_in_t  in_data_reg;
    logic              out_valid_reg;
    clx_pkg::clx_out_t out_data_reg;
    clx_pkg::clx_out_t exec_result;
    logic              fire;

    // Execute when an item is held and the result slot is free or draining
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= exec_result;
        end
    end

    clx_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .result  (exec_result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
